>>> hw/rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants
// Codes, score width and helpers for the global sequence alignment block.
// ----------------------------------------------------------------------------
`default_nettype none
package gsa_pkg;

   // score cells are kept exactly at this width; results are 14 bits
   localparam int SCORE_W = 16;
   localparam int VALUE_W = 14;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   // item actions
   typedef enum logic [1:0] {
      ACT_APPEND_X = 2'd0,
      ACT_APPEND_Y = 2'd1,
      ACT_ALIGN    = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_SCORE  = 3'd0,
      KIND_LENGTH = 3'd1,
      KIND_XCOUNT = 3'd2,
      KIND_XPOS   = 3'd3,
      KIND_YCOUNT = 3'd4,
      KIND_YPOS   = 3'd5
   } kind_type;

   // register indexes
   localparam logic [1:0] REG_MATCH    = 2'd0;
   localparam logic [1:0] REG_MISMATCH = 2'd1;
   localparam logic [1:0] REG_GAP      = 2'd2;

   typedef enum logic [1:0] {
      MOVE_DIAG = 2'd0,
      MOVE_UP   = 2'd1,
      MOVE_LEFT = 2'd2
   } move_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROW0,
      ST_COL0,
      ST_FRD,
      ST_FCALC,
      ST_SRD,
      ST_SCAP,
      ST_TCHK,
      ST_TRD0,
      ST_TRD1,
      ST_TRD2,
      ST_TDEC,
      ST_ESCORE,
      ST_ELEN,
      ST_EXCNT,
      ST_EXPOS,
      ST_EYCNT,
      ST_EYPOS
   } state_type;

   // operands of the shared cell unit
   typedef struct packed {
      score_type diag;
      score_type up;
      score_type left;
      score_type cur;
      logic      eq;
   } cell_in_type;

   typedef struct packed {
      score_type best;
      move_type  move;
   } cell_out_type;

   // clamp a score to the result range
   function automatic value_type sat_value(input score_type s);
      value_type r;
      if (s < -score_type'(8192)) begin
         r = value_type'(-8192);
      end else if (s > score_type'(8191)) begin
         r = value_type'(8191);
      end else begin
         r = s[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gsa_req_if.sv
// ----------------------------------------------------------------------------
// gsa_req_if: input item channel
// Valid/ready channel carrying one load or align item.
// ----------------------------------------------------------------------------
`default_nettype none
interface gsa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] symbol;

   modport source (output valid, output action, output symbol, input ready);
   modport sink   (input valid, input action, input symbol, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/gsa_rsp_if.sv
// ----------------------------------------------------------------------------
// gsa_rsp_if: result item channel
// Valid/ready channel carrying one alignment report item.
// ----------------------------------------------------------------------------
`default_nettype none
interface gsa_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic signed [13:0] value;
   logic              last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink   (input valid, input kind, input value, input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/gsa_cell_unit.sv
// ----------------------------------------------------------------------------
// gsa_cell_unit: shared score cell unit
// Forms the three candidate scores of a cell, picks the best for the fill and
// the traceback move for a known cell value.
// ----------------------------------------------------------------------------
`default_nettype none
module gsa_cell_unit
   import gsa_pkg::*;
(
   input  cell_in_type  cell_in,
   input  logic [7:0]   match_score,
   input  logic [7:0]   mismatch_penalty,
   input  logic [7:0]   gap_penalty,
   output cell_out_type cell_out
);

   score_type ms_s;
   score_type mp_s;
   score_type gp_s;
   score_type dterm;
   score_type uterm;
   score_type lterm;
   score_type best;

   assign ms_s = score_type'({{(SCORE_W-8){1'b0}}, match_score});
   assign mp_s = score_type'({{(SCORE_W-8){1'b0}}, mismatch_penalty});
   assign gp_s = score_type'({{(SCORE_W-8){1'b0}}, gap_penalty});

   // candidates from diagonal, up and left
   assign dterm = cell_in.eq ? (cell_in.diag + ms_s) : (cell_in.diag - mp_s);
   assign uterm = cell_in.up - gp_s;
   assign lterm = cell_in.left - gp_s;

   // maximum, earlier candidate wins ties
   always_comb begin
      best = dterm;
      if (uterm > best) begin
         best = uterm;
      end
      if (lterm > best) begin
         best = lterm;
      end
   end

   // traceback priority: diagonal, then up, then left
   always_comb begin
      cell_out.best = best;
      if (cell_in.cur == dterm) begin
         cell_out.move = MOVE_DIAG;
      end else if (cell_in.cur == uterm) begin
         cell_out.move = MOVE_UP;
      end else begin
         cell_out.move = MOVE_LEFT;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/global_sequence_alignment_top.sv
// ----------------------------------------------------------------------------
// global_sequence_alignment_top: global alignment with linear gap penalty
// Loads two symbol sequences, fills a score matrix and traces back the path.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus takes items: append a symbol to X, append to Y, or align. An
//   align fills the (n+1)x(m+1) score matrix in a memory with one write and
//   one read port, one cell per read state and compute state through one
//   shared cell unit, then traces back, each move taking a check and, off
//   the borders, three memory reads and a decision; req_bus.ready is low
//   until the last result has been taken into the output register.
//   rsp_bus returns score, length, X gap count, X gap positions, Y gap count,
//   Y gap positions; last marks the final item. Results go out through one
//   output register; a stalled receiver holds the sequencer in its emit step.
//   Both sequence lengths clear after an align. Reset clears them, the
//   sequencer and the output valid flag and sets the three registers to 1.
//   The user must write the APB port (4-bit paddr) only while idle, unenforced.
// ----------------------------------------------------------------------------
`default_nettype none
module global_sequence_alignment_top
   import gsa_pkg::*;
#(
   parameter int MAX_LEN = 16
)
(
   input  logic              clock,
   input  logic              reset,
   gsa_req_if.sink           req_bus,
   gsa_rsp_if.source         rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W  = $clog2(2 * MAX_LEN + 1);
   localparam int DEPTH  = (MAX_LEN + 1) * (MAX_LEN + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_LEN + 1);
   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_LEN);

   // configuration registers
   logic [7:0] match_ff, mismatch_ff, gap_ff;

   // sequences and counts
   logic [7:0]       x_sym_ff [MAX_LEN];
   logic [7:0]       y_sym_ff [MAX_LEN];
   logic [CNT_W-1:0] x_cnt_ff, x_cnt_in;
   logic [CNT_W-1:0] y_cnt_ff, y_cnt_in;

   // sequencer and datapath registers
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   score_type        bord_ff, bord_in;
   score_type        diag_ff, diag_in;
   score_type        left_ff, left_in;
   score_type        cur_ff, cur_in;
   score_type        score_ff, score_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] xg_ff, xg_in, yg_ff, yg_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] x_mark_ff [MAX_LEN];
   logic [LEN_W-1:0] y_mark_ff [MAX_LEN];

   // score memory
   score_type         mem [DEPTH];
   score_type         rdata_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   score_type         wr_data;
   logic              wr_en;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  kind_ff, kind_in;
   value_type value_ff, value_in;
   logic      last_ff, last_in;
   logic      out_free;

   // misc
   logic             accept;
   logic             wr_cfg;
   score_type        gp_s;
   logic [CNT_W-1:0] jm1, im1;
   logic             sym_eq;
   cell_in_type      cell_in;
   cell_out_type     cell_out;
   move_type         move;
   logic             do_move;
   logic [LEN_W-1:0] len_p1;

   assign accept   = req_bus.valid && req_bus.ready;
   assign wr_cfg   = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign gp_s     = score_type'({{(SCORE_W-8){1'b0}}, gap_ff});
   assign jm1      = j_ff - 1'b1;
   assign im1      = i_ff - 1'b1;
   assign sym_eq   = x_sym_ff[jm1[IDX_W-1:0]] == y_sym_ff[im1[IDX_W-1:0]];
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign len_p1   = len_ff + 1'b1;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.kind  = kind_ff;
   assign rsp_bus.value = value_ff;
   assign rsp_bus.last  = last_ff;

   // configuration write and read back
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= 8'd1;
         mismatch_ff <= 8'd1;
         gap_ff      <= 8'd1;
      end else if (wr_cfg) begin
         case (paddr[3:2])
            REG_MATCH:    match_ff    <= pwdata[7:0];
            REG_MISMATCH: mismatch_ff <= pwdata[7:0];
            REG_GAP:      gap_ff      <= pwdata[7:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_MATCH:    prdata = {24'd0, match_ff};
         REG_MISMATCH: prdata = {24'd0, mismatch_ff};
         REG_GAP:      prdata = {24'd0, gap_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // shared cell unit: fill uses best, traceback uses move
   always_comb begin
      cell_in.diag = (state_ff == ST_TDEC) ? rdata_ff : diag_ff;
      cell_in.up   = rdata_ff;
      cell_in.left = left_ff;
      cell_in.cur  = cur_ff;
      cell_in.eq   = sym_eq;
      if (state_ff == ST_TDEC) begin
         cell_in.diag = diag_ff;
      end
   end

   gsa_cell_unit u_cell (
      .cell_in          (cell_in),
      .match_score      (match_ff),
      .mismatch_penalty (mismatch_ff),
      .gap_penalty      (gap_ff),
      .cell_out         (cell_out)
   );

   // traceback move, forced on the borders
   always_comb begin
      do_move = 1'b0;
      move    = MOVE_LEFT;
      if (state_ff == ST_TCHK) begin
         if (i_ff == '0 && j_ff != '0) begin
            do_move = 1'b1;
            move    = MOVE_LEFT;
         end else if (j_ff == '0 && i_ff != '0) begin
            do_move = 1'b1;
            move    = MOVE_UP;
         end
      end else if (state_ff == ST_TDEC) begin
         do_move = 1'b1;
         move    = cell_out.move;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_bus.action == ACT_ALIGN) begin
               state_in = ST_ROW0;
            end
         end
         ST_ROW0: begin
            if (j_ff == x_cnt_ff) begin
               state_in = (y_cnt_ff == '0) ? ST_SRD : ST_COL0;
            end
         end
         ST_COL0: begin
            if (x_cnt_ff != '0) begin
               state_in = ST_FRD;
            end else if (i_ff + 1'b1 == y_cnt_ff) begin
               state_in = ST_SRD;
            end
         end
         ST_FRD:   state_in = ST_FCALC;
         ST_FCALC: begin
            if (j_ff != x_cnt_ff) begin
               state_in = ST_FRD;
            end else if (i_ff == y_cnt_ff) begin
               state_in = ST_SRD;
            end else begin
               state_in = ST_COL0;
            end
         end
         ST_SRD:  state_in = ST_SCAP;
         ST_SCAP: state_in = ST_TCHK;
         ST_TCHK: begin
            if (i_ff == '0 && j_ff == '0) begin
               state_in = ST_ESCORE;
            end else if (i_ff != '0 && j_ff != '0) begin
               state_in = ST_TRD0;
            end
         end
         ST_TRD0: state_in = ST_TRD1;
         ST_TRD1: state_in = ST_TRD2;
         ST_TRD2: state_in = ST_TDEC;
         ST_TDEC: state_in = ST_TCHK;
         ST_ESCORE: begin
            if (out_free) begin
               state_in = ST_ELEN;
            end
         end
         ST_ELEN: begin
            if (out_free) begin
               state_in = ST_EXCNT;
            end
         end
         ST_EXCNT: begin
            if (out_free) begin
               state_in = (xg_ff == '0) ? ST_EYCNT : ST_EXPOS;
            end
         end
         ST_EXPOS: begin
            if (out_free && idx_ff == '0) begin
               state_in = ST_EYCNT;
            end
         end
         ST_EYCNT: begin
            if (out_free) begin
               state_in = (yg_ff == '0) ? ST_IDLE : ST_EYPOS;
            end
         end
         ST_EYPOS: begin
            if (out_free && idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, memory ports and result payload
   always_comb begin
      x_cnt_in     = x_cnt_ff;
      y_cnt_in     = y_cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      base_in      = base_ff;
      bord_in      = bord_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      cur_in       = cur_ff;
      score_in     = score_ff;
      len_in       = len_ff;
      xg_in        = xg_ff;
      yg_in        = yg_ff;
      idx_in       = idx_ff;
      rd_addr      = base_ff + ADDR_W'(j_ff);
      wr_addr      = base_ff + ADDR_W'(j_ff);
      wr_data      = bord_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.action == ACT_APPEND_X && x_cnt_ff < CNT_MAX) begin
                  x_cnt_in = x_cnt_ff + 1'b1;
               end
               if (req_bus.action == ACT_APPEND_Y && y_cnt_ff < CNT_MAX) begin
                  y_cnt_in = y_cnt_ff + 1'b1;
               end
               i_in    = '0;
               j_in    = '0;
               base_in = '0;
               bord_in = '0;
            end
         end
         // top border: write -gap*j, then restart bord at zero for the left border
         ST_ROW0: begin
            wr_en   = 1'b1;
            wr_data = bord_ff;
            bord_in = bord_ff - gp_s;
            j_in    = j_ff + 1'b1;
            if (j_ff == x_cnt_ff) begin
               bord_in = '0;
               j_in    = j_ff;
            end
         end
         // left border of the next row
         ST_COL0: begin
            wr_en   = 1'b1;
            wr_addr = base_ff + STRIDE;
            wr_data = bord_ff - gp_s;
            base_in = base_ff + STRIDE;
            bord_in = bord_ff - gp_s;
            diag_in = bord_ff;
            left_in = bord_ff - gp_s;
            i_in    = i_ff + 1'b1;
            j_in    = CNT_W'(1);
         end
         ST_FRD: begin
            rd_addr = base_ff - STRIDE + ADDR_W'(j_ff);
         end
         ST_FCALC: begin
            wr_en   = 1'b1;
            wr_data = cell_out.best;
            left_in = cell_out.best;
            diag_in = rdata_ff;
            if (j_ff != x_cnt_ff) begin
               j_in = j_ff + 1'b1;
            end
         end
         // read the far corner, start the traceback
         ST_SRD: begin
            rd_addr = base_ff + ADDR_W'(x_cnt_ff);
            i_in    = y_cnt_ff;
            j_in    = x_cnt_ff;
            len_in  = '0;
            xg_in   = '0;
            yg_in   = '0;
         end
         ST_SCAP: begin
            score_in = rdata_ff;
         end
         ST_TRD0: begin
            rd_addr = base_ff + ADDR_W'(j_ff);
         end
         ST_TRD1: begin
            cur_in  = rdata_ff;
            rd_addr = base_ff - STRIDE + ADDR_W'(jm1);
         end
         ST_TRD2: begin
            diag_in = rdata_ff;
            rd_addr = base_ff - STRIDE + ADDR_W'(j_ff);
         end
         ST_ESCORE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_SCORE;
               value_in     = sat_value(score_ff);
               last_in      = 1'b0;
            end
         end
         ST_ELEN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_LENGTH;
               value_in     = value_type'(len_ff);
               last_in      = 1'b0;
            end
         end
         ST_EXCNT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_XCOUNT;
               value_in     = value_type'(xg_ff);
               last_in      = 1'b0;
               idx_in       = xg_ff - 1'b1;
            end
         end
         ST_EXPOS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_XPOS;
               value_in     = value_type'(len_p1 - x_mark_ff[idx_ff[IDX_W-1:0]]);
               last_in      = 1'b0;
               idx_in       = idx_ff - 1'b1;
            end
         end
         ST_EYCNT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_YCOUNT;
               value_in     = value_type'(yg_ff);
               last_in      = (yg_ff == '0);
               idx_in       = yg_ff - 1'b1;
               if (yg_ff == '0) begin
                  x_cnt_in = '0;
                  y_cnt_in = '0;
               end
            end
         end
         ST_EYPOS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_YPOS;
               value_in     = value_type'(len_p1 - y_mark_ff[idx_ff[IDX_W-1:0]]);
               last_in      = (idx_ff == '0);
               idx_in       = idx_ff - 1'b1;
               if (idx_ff == '0) begin
                  x_cnt_in = '0;
                  y_cnt_in = '0;
               end
            end
         end
         default: ;
      endcase
      // advance the traceback position
      if (do_move) begin
         len_in = len_p1;
         case (move)
            MOVE_DIAG: begin
               i_in    = im1;
               j_in    = jm1;
               base_in = base_ff - STRIDE;
            end
            MOVE_UP: begin
               i_in    = im1;
               base_in = base_ff - STRIDE;
               xg_in   = xg_ff + 1'b1;
            end
            default: begin
               j_in  = jm1;
               yg_in = yg_ff + 1'b1;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_cnt_ff     <= '0;
         y_cnt_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_cnt_ff     <= x_cnt_in;
         y_cnt_ff     <= y_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      base_ff  <= base_in;
      bord_ff  <= bord_in;
      diag_ff  <= diag_in;
      left_ff  <= left_in;
      cur_ff   <= cur_in;
      score_ff <= score_in;
      len_ff   <= len_in;
      xg_ff    <= xg_in;
      yg_ff    <= yg_in;
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   // symbol stores and gap marks
   always_ff @(posedge clock) begin
      if (accept && req_bus.action == ACT_APPEND_X && x_cnt_ff < CNT_MAX) begin
         x_sym_ff[x_cnt_ff[IDX_W-1:0]] <= req_bus.symbol;
      end
      if (accept && req_bus.action == ACT_APPEND_Y && y_cnt_ff < CNT_MAX) begin
         y_sym_ff[y_cnt_ff[IDX_W-1:0]] <= req_bus.symbol;
      end
      if (do_move && move == MOVE_UP && xg_ff < CNT_MAX) begin
         x_mark_ff[xg_ff[IDX_W-1:0]] <= len_p1;
      end
      if (do_move && move == MOVE_LEFT && yg_ff < CNT_MAX) begin
         y_mark_ff[yg_ff[IDX_W-1:0]] <= len_p1;
      end
   end

   // score memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // lengths never pass the sequence capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      x_cnt_ff <= CNT_MAX && y_cnt_ff <= CNT_MAX)
      else $error("sequence length beyond capacity");

   // traceback stays inside the filled matrix
   a_tb_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TCHK |-> i_ff <= y_cnt_ff && j_ff <= x_cnt_ff &&
      len_ff <= LEN_W'(x_cnt_ff) + LEN_W'(y_cnt_ff))
      else $error("traceback outside matrix");

   // lengths are cleared once an alignment report completes
   a_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE && state_in == ST_IDLE |=> x_cnt_ff == '0 && y_cnt_ff == '0)
      else $error("lengths not cleared after align");

endmodule
`default_nettype wire
